// ----- rtl/sha_pkg.sv -----
// Package for the SHA-256 message hasher: round constants, initial hash
// values, sequencer state type and round helper functions. No dependencies.
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;
	localparam int unsigned ChainWords = 8;
	localparam logic [7:0] PadByte = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} seq_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- rtl/sha_round.sv -----
// One SHA-256 round and one message schedule step, shared over all rounds.
// Uses sha_pkg.
module sha_round (
	input  logic [31:0] v_in [8],
	input  logic [31:0] w_in [16],
	input  logic [5:0]  round_idx,
	output logic [31:0] v_out [8],
	output logic [31:0] w_next
);
	import sha_pkg::*;

	logic [31:0] big1, big0, choose, major, t1, t2, s0, s1;

	always_comb begin
		big1 = rotr(v_in[4], 6) ^ rotr(v_in[4], 11) ^ rotr(v_in[4], 25);
		choose = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
		t1 = v_in[7] + big1 + choose + round_k(round_idx) + w_in[0];
		big0 = rotr(v_in[0], 2) ^ rotr(v_in[0], 13) ^ rotr(v_in[0], 22);
		major = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
		t2 = big0 + major;
		v_out[0] = t1 + t2;
		v_out[1] = v_in[0];
		v_out[2] = v_in[1];
		v_out[3] = v_in[2];
		v_out[4] = v_in[3] + t1;
		v_out[5] = v_in[4];
		v_out[6] = v_in[5];
		v_out[7] = v_in[6];
		// schedule word for round+16 from the sliding window
		s0 = rotr(w_in[1], 7) ^ rotr(w_in[1], 18) ^ (w_in[1] >> 3);
		s1 = rotr(w_in[14], 17) ^ rotr(w_in[14], 19) ^ (w_in[14] >> 10);
		w_next = w_in[0] + s0 + w_in[9] + s1;
	end

endmodule

// ----- rtl/sha256_message_hasher.sv -----
// SHA-256 message hasher top level: byte collection, padding sequencer and
// the round loop around sha_round. Uses sha_pkg.
//
// Bytes are taken one per cycle while a block fills. When the 64th byte of a
// block arrives, or a request carries message_end, stall rises while the
// shared round unit works. The 16 schedule words are loaded from the block
// store one byte per cycle behind its registered read; the 64 rounds and the
// chaining add follow, and input stays held off for the whole block. A
// closing request first writes the padding, one byte a cycle from the first
// free position to the end of the block (1 to 64 bytes), and then compresses
// that block. A second final block follows when 56 or more bytes sit in the
// block: padding over all 64 positions, then another compression. When
// the closing byte fills the block, that block is compressed first and then
// a fresh block of padding follows. Finally the eight digest words are
// presented, one per accepted output request, so output stalls lengthen the
// busy time one for one. The block store is a 64 x 8 memory with one write
// and one registered read port.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import sha_pkg::*;

	logic [7:0]  mem [BlockBytes];
	logic [7:0]  rd_q;
	seq_state_t  state_q, state_d;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] v_next [8];
	logic [31:0] w_next;
	logic [6:0]  cnt_q;
	logic        closing_q;
	logic        second_q;
	logic        padded_q;
	logic [2:0]  out_idx_q;

	logic        accept;
	logic [5:0]  pad_pos;
	logic        pad_done;
	logic [5:0]  load_addr;
	logic        we;
	logic [5:0]  waddr;
	logic [7:0]  wdata;

	sha_round u_round (
		.v_in(v_q),
		.w_in(w_q),
		.round_idx(cnt_q[5:0]),
		.v_out(v_next),
		.w_next(w_next)
	);

	assign accept = in_valid && !in_stall;
	assign pad_pos = cnt_q[5:0];

	// padding byte for position pos of the final block(s)
	function automatic logic [7:0] pad_byte(input logic [5:0] pos, input logic [5:0] fill,
			input logic second, input logic [63:0] len);
		logic [7:0] b;
		b = 8'h00;
		if (!second && pos == fill) begin
			b = PadByte;
		end
		if (pos >= 6'd56 && (second || fill < 6'd56)) begin
			b = len[8 * (63 - pos) +: 8];
		end
		return b;
	endfunction

	// ST_PAD sweeps from fill (or 0 for a second block) to 63
	assign pad_done = (pad_pos == 6'd63);

	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = data_byte;
		if (state_q == ST_IDLE && accept && byte_present) begin
			we = 1'b1;
		end else if (state_q == ST_PAD) begin
			we = 1'b1;
			waddr = pad_pos;
			wdata = pad_byte(pad_pos, fill_q, second_q, bitlen_q);
		end
	end

	// load reads 64 bytes, one per cycle; cnt counts 0..64 since the read is registered
	assign load_addr = cnt_q[5:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[load_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (byte_present && fill_q == 6'd63) begin
						state_d = ST_LOAD;
					end else if (message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: if (pad_done) state_d = ST_LOAD;
			ST_LOAD: if (cnt_q == 7'd64) state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 7'(Rounds - 1)) state_d = ST_ADD;
			ST_ADD: begin
				if (!closing_q) begin
					state_d = ST_IDLE;
				end else if (!padded_q || (!second_q && fill_q >= 6'd56)) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: if (!out_stall && out_idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bitlen_q <= '0;
			cnt_q <= '0;
			closing_q <= 1'b0;
			second_q <= 1'b0;
			padded_q <= 1'b0;
			out_idx_q <= '0;
			for (int i = 0; i < ChainWords; i++) chain_q[i] <= init_h(3'(i));
			for (int i = 0; i < ChainWords; i++) v_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					second_q <= 1'b0;
					padded_q <= 1'b0;
					// a full block with end pads a fresh block after compressing
					if (accept && message_end && !(byte_present && fill_q == 6'd63)) begin
						cnt_q <= {1'b0, fill_q + 6'(byte_present)};
					end else begin
						cnt_q <= '0;
					end
					if (accept) begin
						closing_q <= message_end;
						if (byte_present) begin
							bitlen_q <= bitlen_q + 64'd8;
							fill_q <= fill_q + 6'd1;
						end
					end
				end
				ST_PAD: begin
					padded_q <= 1'b1;
					cnt_q <= pad_done ? 7'd0 : cnt_q + 7'd1;
				end
				ST_LOAD: begin
					cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
					// advance the window as each word begins; bytes enter big-endian
					if (cnt_q != 7'd0) begin
						if (cnt_q[1:0] == 2'd1) begin
							for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
						end
						w_q[15] <= {w_q[15][23:0], rd_q};
					end
					for (int i = 0; i < ChainWords; i++) v_q[i] <= chain_q[i];
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					for (int i = 0; i < ChainWords; i++) v_q[i] <= v_next[i];
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= w_next;
				end
				ST_ADD: begin
					// fill is zero when padding follows a full data block
					cnt_q <= '0;
					for (int i = 0; i < ChainWords; i++) chain_q[i] <= chain_q[i] + v_q[i];
					if (closing_q && padded_q && !second_q && fill_q >= 6'd56) begin
						second_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							fill_q <= '0;
							bitlen_q <= '0;
							closing_q <= 1'b0;
							for (int i = 0; i < ChainWords; i++) chain_q[i] <= init_h(3'(i));
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		digest_word = chain_q[out_idx_q];
		word_index = out_idx_q;
		final_word = (out_idx_q == 3'd7);
	end

endmodule

// ----- sim/tb.sv -----
// Testbench for sha256_message_hasher: streams byte requests, predicts each
// digest with a local SHA-256 model and checks the eight words per message.
// Depends on rtl/sha_pkg.sv and rtl/sha256_message_hasher.sv.
module tb;
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_entry_t;

	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned HoldOffLen = 600;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        message_end;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	int unsigned block_fill;
	logic [63:0] msg_bits;

	digest_entry_t expected_words[$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_off_cycles;
	logic        hold_off_go;
	logic        hold_armed;

	sha256_message_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .final_word(final_word)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		block_fill = 0;
		msg_bits = '0;
	endtask

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		v = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic predict_digest(logic [7:0] b, logic present, logic closing);
		if (present) begin
			msg_block[block_fill] = b;
			msg_bits += 64'd8;
			block_fill++;
			if (block_fill == 64) begin
				compress();
				block_fill = 0;
			end
		end
		if (!closing)
			return;
		msg_block[block_fill] = PadByte;
		for (int i = block_fill + 1; i < 64; i++)
			msg_block[i] = '0;
		if (block_fill >= 56) begin
			compress();
			for (int i = 0; i < 64; i++)
				msg_block[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			msg_block[63-i] = msg_bits[8*i +: 8];
		compress();
		for (int i = 0; i < 8; i++)
			expected_words.push_back('{hash_state[i], 3'(i), i == 7});
		restart_hash();
	endtask

	// Hold each request until accepted; sender idles at its current rate.
	task automatic send_byte(logic [7:0] b, logic present, logic closing);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= present;
		message_end <= closing;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_digest(b, present, closing);
	endtask

	task automatic send_message(int unsigned len, bit end_with_byte);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b1, end_with_byte && i == len - 1);
		if (!end_with_byte || len == 0)
			send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	// Drop valid and wait until every expected word has come.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b1, 1'b1);
		send_byte(8'h61, 1'b1, 1'b0);
		send_byte(8'h62, 1'b1, 1'b0);
		send_byte(8'h63, 1'b1, 1'b1);
		send_byte(8'h55, 1'b1, 1'b0);
		send_byte(8'haa, 1'b0, 1'b0);
		send_byte(8'haa, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		drain();
	endtask

	// Lengths around the one- and two-block padding boundaries.
	task automatic test_boundaries();
		int unsigned lens [4];
		lens = '{55, 56, 63, 64};
		foreach (lens[i])
			send_message(lens[i], i[0]);
		drain();
	endtask

	task automatic test_random(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_byte(8'($urandom), 1'b0, 1'b0);
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
				send_message(len, 1'($urandom_range(1)));
				sent += len + 1;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_off_go = 1'b1;
		send_idle_pct = 0;
		send_message(20, 1'b0);
		send_message(3, 1'b1);
		send_message(0, 1'b0);
		drain();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_off_cycles <= 0;
			hold_armed <= 1'b0;
		end else if (hold_off_go && !hold_armed) begin
			out_stall <= 1'b1;
			hold_off_cycles <= HoldOffLen - 1;
			hold_armed <= 1'b1;
		end else if (hold_off_cycles != 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		digest_entry_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h index %0d", digest_word, word_index);
			end else begin
				exp_w = expected_words.pop_front();
				if (exp_w != {digest_word, word_index, final_word}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
							exp_w.word, exp_w.idx, exp_w.last,
							digest_word, word_index, final_word);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("FAIL sha256_message_hasher");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_present = 1'b0;
		message_end = 1'b0;
		hold_off_go = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		restart_hash();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_boundaries();
		test_random(25);
		send_idle_pct = 63;
		test_random(25);
		send_idle_pct = 0;
		recv_stall_pct = 63;
		test_random(25);
		send_idle_pct = 32;
		recv_stall_pct = 32;
		test_random(25);
		drain();
		recv_stall_pct = 20;
		test_backpressure();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASS sha256_message_hasher");
		else
			$display("FAIL sha256_message_hasher");
		$finish;
	end

endmodule

// ----- sha256_message_hasher.f -----
rtl/sha_pkg.sv
rtl/sha_round.sv
rtl/sha256_message_hasher.sv
sim/tb.sv
